// ===== sv/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, widths and codes for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int CNT_W       = 7;   // frame counts, base, window bounds
    localparam int FRAME_W     = 6;   // frame number field
    localparam int ACK_W       = 8;   // acknowledged number field
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 7;   // widest configuration register
    localparam int REG_IDX_W   = 1;

    localparam int MAX_FRAMES_DEF = 64;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEN     = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 7'd64;
    localparam logic [CFG_W-1:0] WIN_LEN_RST     = 7'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 2'd3;

    // Request kinds
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_ACK  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [ACK_W-1:0] ack_number;
    } srsw_in_t;

    typedef struct packed {
        logic                is_frame;
        logic [FRAME_W-1:0]  frame_number;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    window_base;
        logic                all_done;
        logic                last;
    } srsw_out_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic slide;
        logic ack;
        logic scan;
        logic emit_frame;
        logic emit_status;
    } srsw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_ack;
        logic found;
        logic out_free;
    } srsw_sts_t;

    // Saturate a count register to 1..maxv
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (CNT_W'(v) > maxv)
            r = maxv;
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

// ===== sv/selective_repeat_sender_window_top.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Sender side of a selective-repeat ARQ window. Each request item is either a
// send round or an acknowledgment. A send round yields, in ascending order,
// one item per unacknowledged frame from the window base up to
// base + window - 1 (capped at the frame count), with last set on the final
// one, or a single "nothing to send" status item. An acknowledgment yields
// one status item (accepted, duplicate or out of range) after marking the
// frame and advancing the base. Both registers are saturated to
// 1..MAX_FRAME_COUNT and take effect on the next item only if written while
// idle, which the block does not enforce. The block takes one item at a
// time; an acknowledgment steps the sequencer through slide, ack, slide and
// status phases, and a send round through slide and scan phases, then one
// emit phase per frame (or a status phase when nothing is sent), around a
// single combinational priority search over the bitmap.
// The result register lets a new item be accepted while the previous
// result still waits for res_ready; frames of a round stall on res_ready.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top #(
    parameter int MAX_FRAME_COUNT = srsw_pkg::MAX_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [srsw_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_W-1:0]      cfg_data,
    // request channel
    input  logic                            req_valid,
    output logic                            req_ready,
    input  srsw_pkg::srsw_in_t              req_item,
    // result channel
    output logic                            res_valid,
    input  logic                            res_ready,
    output srsw_pkg::srsw_out_t             res_item
);
    import srsw_pkg::*;

    // Command and status between sequencer and datapath
    srsw_cmd_t cmd;
    srsw_sts_t sts;

    // Sequencer: hold in idle until an item arrives, then drive the
    // datapath through its phases, pausing emission while the result
    // register is still full.
    srsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: bitmap, base, search unit and result register.
    srsw_dp #(
        .MAX_FRAME_COUNT (MAX_FRAME_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sv/srsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer for the sender window: steps the datapath through slide, ack,
// scan and emit phases for each accepted item.
// ----------------------------------------------------------------------------
module srsw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  srsw_pkg::srsw_sts_t sts,
    output srsw_pkg::srsw_cmd_t cmd
);
    import srsw_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SLIDE     = 3'd1;
    localparam logic [2:0] S_ACK       = 3'd2;
    localparam logic [2:0] S_ACK_SLIDE = 3'd3;
    localparam logic [2:0] S_SCAN      = 3'd4;
    localparam logic [2:0] S_FRAME     = 3'd5;
    localparam logic [2:0] S_STATUS    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SLIDE;
                end
            end
            S_SLIDE:
            begin
                cmd.slide  = 1'b1;
                state_next = sts.is_ack ? S_ACK : S_SCAN;
            end
            S_ACK:
            begin
                cmd.ack    = 1'b1;
                state_next = S_ACK_SLIDE;
            end
            S_ACK_SLIDE:
            begin
                cmd.slide  = 1'b1;
                state_next = S_STATUS;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = sts.found ? S_FRAME : S_STATUS;
            end
            S_FRAME:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_frame = 1'b1;
                    if (!sts.found)
                        state_next = S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("srsw_ctrl: more than one datapath command at once");

    a_emit_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_frame || cmd.emit_status) |-> sts.out_free)
        else $error("srsw_ctrl: result loaded while output register full");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (state_reg == S_SLIDE))
        else $error("srsw_ctrl: accepted item did not start with a slide");
`endif

endmodule

// ===== sv/srsw_dp.sv =====
// ----------------------------------------------------------------------------
// srsw_dp
// Datapath: configuration registers, acknowledged bitmap, window base,
// bounded first-unacknowledged search and the result register.
// ----------------------------------------------------------------------------
module srsw_dp #(
    parameter int MAX_FRAME_COUNT = srsw_pkg::MAX_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srsw_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_W-1:0]      cfg_data,
    input  srsw_pkg::srsw_in_t              req_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output srsw_pkg::srsw_out_t             res_item,
    input  srsw_pkg::srsw_cmd_t             cmd,
    output srsw_pkg::srsw_sts_t             sts
);
    import srsw_pkg::*;

    localparam int IDX_W = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_COUNT);

    logic [CFG_W-1:0]           total_cfg_reg;
    logic [CFG_W-1:0]           window_cfg_reg;
    logic [MAX_FRAME_COUNT-1:0] acked_reg;
    logic [CNT_W-1:0]           base_reg;
    logic                       req_type_reg;
    logic [ACK_W-1:0]           ack_num_reg;
    logic [CNT_W-1:0]           nxt_reg;
    logic [CNT_W-1:0]           end_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic                       out_valid_reg;
    srsw_out_t                  out_item_reg;

    logic [CNT_W-1:0] total_eff;
    logic [CNT_W-1:0] window_eff;
    logic [CNT_W:0]   end_sum;
    logic [CNT_W-1:0] end_calc;
    logic [CNT_W-1:0] search_lo;
    logic [CNT_W-1:0] search_hi;
    logic             search_found;
    logic [CNT_W-1:0] search_idx;
    logic             ack_in_range;
    logic             ack_dup;
    logic             out_free;

    assign total_eff  = clamp_count(total_cfg_reg, MAX_CNT);
    assign window_eff = clamp_count(window_cfg_reg, MAX_CNT);

    assign end_sum  = {1'b0, base_reg} + {1'b0, window_eff};
    assign end_calc = (end_sum > {1'b0, total_eff}) ? total_eff : end_sum[CNT_W-1:0];

    assign ack_in_range = (ack_num_reg < {1'b0, total_eff});
    assign ack_dup      = acked_reg[ack_num_reg[IDX_W-1:0]];

    assign out_free = !out_valid_reg || res_ready;

    // Search bounds per phase
    always_comb
    begin
        priority if (cmd.scan)
        begin
            search_lo = base_reg;
            search_hi = end_calc;
        end
        else if (cmd.slide)
        begin
            search_lo = base_reg;
            search_hi = total_eff;
        end
        else
        begin
            search_lo = nxt_reg + CNT_W'(1);
            search_hi = end_reg;
        end
    end

    // Lowest unacknowledged frame in [lo, hi)
    always_comb
    begin
        search_found = 1'b0;
        search_idx   = '0;
        for (int i = MAX_FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (!acked_reg[i] && (CNT_W'(i) >= search_lo) && (CNT_W'(i) < search_hi))
            begin
                search_found = 1'b1;
                search_idx   = CNT_W'(i);
            end
        end
    end

    assign sts.is_ack   = (req_type_reg == REQ_ACK);
    assign sts.found    = search_found;
    assign sts.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_cfg_reg  <= FRAME_COUNT_RST;
            window_cfg_reg <= WIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT: total_cfg_reg  <= cfg_data;
                REG_WIN_LEN:     window_cfg_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Advance the base past acknowledged frames below the total
            if (cmd.slide && (base_reg < total_eff))
                base_reg <= search_found ? search_idx : total_eff;
            if (cmd.ack && ack_in_range && !ack_dup)
                acked_reg[ack_num_reg[IDX_W-1:0]] <= 1'b1;
            if (cmd.emit_frame || cmd.emit_status)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg <= req_item.req_type;
            ack_num_reg  <= req_item.ack_number;
        end
        if (cmd.ack)
        begin
            priority if (!ack_in_range)
                status_reg <= ST_RANGE;
            else if (ack_dup)
                status_reg <= ST_DUPLICATE;
            else
                status_reg <= ST_OK;
        end
        if (cmd.scan)
        begin
            if (search_found)
                nxt_reg <= search_idx;
            else
                status_reg <= ST_NOTHING;
            end_reg <= end_calc;
        end
        if (cmd.emit_frame)
        begin
            out_item_reg.is_frame     <= 1'b1;
            out_item_reg.frame_number <= nxt_reg[FRAME_W-1:0];
            out_item_reg.status       <= ST_OK;
            out_item_reg.window_base  <= base_reg;
            out_item_reg.all_done     <= (base_reg >= total_eff);
            out_item_reg.last         <= !search_found;
            nxt_reg                   <= search_idx;
        end
        if (cmd.emit_status)
        begin
            out_item_reg.is_frame     <= 1'b0;
            out_item_reg.frame_number <= '0;
            out_item_reg.status       <= status_reg;
            out_item_reg.window_base  <= base_reg;
            out_item_reg.all_done     <= (base_reg >= total_eff);
            out_item_reg.last         <= 1'b1;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

`ifndef SYNTHESIS
    a_base_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg >= $past(base_reg))
        else $error("srsw_dp: window base moved backwards");

    a_ack_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ack && ack_in_range && !ack_dup) |=> acked_reg[$past(ack_num_reg[IDX_W-1:0])])
        else $error("srsw_dp: accepted ack did not mark its frame");

    a_frame_unacked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_frame |-> (!acked_reg[nxt_reg[IDX_W-1:0]] && (nxt_reg < end_reg)))
        else $error("srsw_dp: emitted frame is acknowledged or outside the round");
`endif

endmodule
